### rtl/core/dqfs_pkg.sv
package dqfs_pkg;

	localparam int DEF_FIELD_CAPACITY = 256;
	localparam int DEF_COLUMN_LIMIT   = 6;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;

	localparam logic [7:0] RST_DELIMITER   = 8'h7c;
	localparam logic [7:0] RST_QUOTE       = 8'h22;
	localparam logic [2:0] RST_MAX_COLUMNS = 3'd6;

	typedef enum logic [1:0] {
		REG_DELIMITER   = 2'd0,
		REG_QUOTE       = 2'd1,
		REG_MAX_COLUMNS = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_LONG    = 2'd0,
		ERR_COLUMNS = 2'd1,
		ERR_QUOTE   = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0] delimiter_byte;
		logic [7:0] quote_byte;
		logic [2:0] max_columns;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [2:0] column_number;
		logic [7:0] field_length;
		logic       line_done;
		logic [2:0] column_count;
		err_t       error_code;
	} res_t;

endpackage

### rtl/core/delimited_quoted_field_splitter.sv
// Channel | Handshake             | Payload
// --------+-----------------------+--------------------------------------------
// in      | in_valid / in_ready   | text_byte
// out     | out_valid / out_ready | kind, data_byte, column_number,
//         |                       | field_length, line_done, column_count,
//         |                       | error_code
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained, unless a stalled result blocks an item that produces a result.
// Each item is registered, then one combinational pass over the line state
// produces the result register contents and the next state.
// Reset clears line state and loads delimiter '|', quote '"', six columns.
// A stalled result holds only items that produce a result; items that
// produce none keep moving.
module delimited_quoted_field_splitter
	import dqfs_pkg::*;
#(
	parameter int FIELD_CAPACITY = DEF_FIELD_CAPACITY,
	parameter int COLUMN_LIMIT   = DEF_COLUMN_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [2:0] column_number,
	output logic [7:0] field_length,
	output logic       line_done,
	output logic [2:0] column_count,
	output logic [1:0] error_code,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int CNT_W = $clog2(FIELD_CAPACITY);
	localparam int COL_W = $clog2(COLUMN_LIMIT + 1);

	cfg_t             cfg;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	res_t             res_s2;
	logic             skip_q;
	logic             in_quotes_q;
	logic             q_pending_q;
	logic [COL_W-1:0] column_q;
	logic [CNT_W-1:0] bytes_q;
	logic             skip_nxt;
	logic             in_quotes_nxt;
	logic             q_pending_nxt;
	logic [COL_W-1:0] column_nxt;
	logic [CNT_W-1:0] bytes_nxt;
	logic             has_res;
	res_t             res;
	logic             out_free;
	logic             advance;

	assign cfg_ready = 1'b1;

	dqfs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dqfs_step #(
		.FIELD_CAPACITY (FIELD_CAPACITY),
		.COLUMN_LIMIT   (COLUMN_LIMIT)
	) u_step (
		.cfg           (cfg),
		.text_byte     (byte_s1),
		.skip          (skip_q),
		.in_quotes     (in_quotes_q),
		.q_pending     (q_pending_q),
		.column        (column_q),
		.bytes         (bytes_q),
		.skip_nxt      (skip_nxt),
		.in_quotes_nxt (in_quotes_nxt),
		.q_pending_nxt (q_pending_nxt),
		.column_nxt    (column_nxt),
		.bytes_nxt     (bytes_nxt),
		.has_res       (has_res),
		.res           (res)
	);

	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && (!has_res || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q      <= 1'b0;
			in_quotes_q <= 1'b0;
			q_pending_q <= 1'b0;
			column_q    <= '0;
			bytes_q     <= '0;
		end else if (advance) begin
			skip_q      <= skip_nxt;
			in_quotes_q <= in_quotes_nxt;
			q_pending_q <= q_pending_nxt;
			column_q    <= column_nxt;
			bytes_q     <= bytes_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = res_s2.kind;
	assign data_byte     = res_s2.data_byte;
	assign column_number = res_s2.column_number;
	assign field_length  = res_s2.field_length;
	assign line_done     = res_s2.line_done;
	assign column_count  = res_s2.column_count;
	assign error_code    = res_s2.error_code;

	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> !in_quotes_q && !q_pending_q && (column_q == '0) && (bytes_q == '0))
		else $error("skipping with live line state");

	a_quote_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ERROR) && (error_code == ERR_QUOTE) |-> line_done)
		else $error("unterminated quote error without line end");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DATA)
		|-> (field_length == 8'd0) && (column_count == 3'd0) && !line_done)
		else $error("data item carries field end information");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && has_res && !out_free |=> valid_s1 && $stable(byte_s1))
		else $error("blocked item left the input stage");

endmodule

### rtl/core/dqfs_cfg.sv
module dqfs_cfg
	import dqfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_byte <= RST_DELIMITER;
			cfg_q.quote_byte     <= RST_QUOTE;
			cfg_q.max_columns    <= RST_MAX_COLUMNS;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DELIMITER:   cfg_q.delimiter_byte <= wr_data;
				REG_QUOTE:       cfg_q.quote_byte     <= wr_data;
				REG_MAX_COLUMNS: cfg_q.max_columns    <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/dqfs_step.sv
module dqfs_step
	import dqfs_pkg::*;
#(
	parameter int FIELD_CAPACITY = DEF_FIELD_CAPACITY,
	parameter int COLUMN_LIMIT   = DEF_COLUMN_LIMIT,
	localparam int CNT_W = $clog2(FIELD_CAPACITY),
	localparam int COL_W = $clog2(COLUMN_LIMIT + 1)
) (
	input  cfg_t             cfg,
	input  logic [7:0]       text_byte,
	input  logic             skip,
	input  logic             in_quotes,
	input  logic             q_pending,
	input  logic [COL_W-1:0] column,
	input  logic [CNT_W-1:0] bytes,
	output logic             skip_nxt,
	output logic             in_quotes_nxt,
	output logic             q_pending_nxt,
	output logic [COL_W-1:0] column_nxt,
	output logic [CNT_W-1:0] bytes_nxt,
	output logic             has_res,
	output res_t             res
);

	logic             at_end;
	logic             is_quote;
	logic             is_delim;
	logic [COL_W-1:0] col_lim;
	logic [COL_W:0]   col_inc;
	logic [CNT_W:0]   bytes_inc;
	logic             too_long;
	logic             go_on;
	logic             eff_quotes;
	logic             do_store;

	assign at_end   = (text_byte == CH_NUL) || (text_byte == CH_LF) || (text_byte == CH_CR);
	assign is_quote = (text_byte == cfg.quote_byte);
	assign is_delim = (text_byte == cfg.delimiter_byte);
	assign col_lim  = ((cfg.max_columns == 3'd0) || (32'(cfg.max_columns) > COLUMN_LIMIT))
		? COL_W'(COLUMN_LIMIT) : COL_W'(cfg.max_columns);
	assign col_inc   = {1'b0, column} + 1'b1;
	assign bytes_inc = {1'b0, bytes} + 1'b1;
	assign too_long  = (bytes_inc >= (CNT_W+1)'(FIELD_CAPACITY));

	always_comb begin
		skip_nxt          = skip;
		in_quotes_nxt     = in_quotes;
		q_pending_nxt     = q_pending;
		column_nxt        = column;
		bytes_nxt         = bytes;
		has_res           = 1'b0;
		res.kind          = KIND_DATA;
		res.data_byte     = 8'd0;
		res.column_number = 3'(column);
		res.field_length  = 8'd0;
		res.line_done     = 1'b0;
		res.column_count  = 3'd0;
		res.error_code    = ERR_LONG;
		go_on             = 1'b0;
		eff_quotes        = in_quotes;
		do_store          = 1'b0;

		if (skip) begin
			if (at_end) begin
				skip_nxt      = 1'b0;
				in_quotes_nxt = 1'b0;
				q_pending_nxt = 1'b0;
				column_nxt    = '0;
				bytes_nxt     = '0;
			end
		end else begin
			if (q_pending) begin
				q_pending_nxt = 1'b0;
				if (is_quote) begin
					do_store = 1'b1;
				end else begin
					in_quotes_nxt = 1'b0;
					eff_quotes    = 1'b0;
					go_on         = 1'b1;
				end
			end else if (is_quote) begin
				if (in_quotes) begin
					q_pending_nxt = 1'b1;
				end else begin
					in_quotes_nxt = 1'b1;
				end
			end else begin
				go_on = 1'b1;
			end

			if (go_on) begin
				if (eff_quotes) begin
					if (at_end) begin
						has_res        = 1'b1;
						res.kind       = KIND_ERROR;
						res.line_done  = 1'b1;
						res.error_code = ERR_QUOTE;
						in_quotes_nxt  = 1'b0;
						q_pending_nxt  = 1'b0;
						column_nxt     = '0;
						bytes_nxt      = '0;
					end else begin
						do_store = 1'b1;
					end
				end else if (at_end || is_delim) begin
					has_res = 1'b1;
					if (column >= col_lim) begin
						res.kind       = KIND_ERROR;
						res.line_done  = at_end;
						res.error_code = ERR_COLUMNS;
						in_quotes_nxt  = 1'b0;
						q_pending_nxt  = 1'b0;
						column_nxt     = '0;
						bytes_nxt      = '0;
						skip_nxt       = !at_end;
					end else if (at_end) begin
						res.kind         = KIND_END;
						res.field_length = 8'(bytes);
						res.line_done    = 1'b1;
						res.column_count = 3'(col_inc);
						in_quotes_nxt    = 1'b0;
						q_pending_nxt    = 1'b0;
						column_nxt       = '0;
						bytes_nxt        = '0;
					end else begin
						res.kind         = KIND_END;
						res.field_length = 8'(bytes);
						column_nxt       = COL_W'(col_inc);
						bytes_nxt        = '0;
					end
				end else begin
					do_store = 1'b1;
				end
			end

			if (do_store) begin
				has_res = 1'b1;
				if (too_long) begin
					res.kind       = KIND_ERROR;
					res.error_code = ERR_LONG;
					in_quotes_nxt  = 1'b0;
					q_pending_nxt  = 1'b0;
					column_nxt     = '0;
					bytes_nxt      = '0;
					skip_nxt       = 1'b1;
				end else begin
					res.kind      = KIND_DATA;
					res.data_byte = text_byte;
					bytes_nxt     = CNT_W'(bytes_inc);
				end
			end
		end
	end

endmodule

### sim/delimited_quoted_field_splitter_test.sv
module delimited_quoted_field_splitter_test
	import dqfs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int ITEMS_PER_PHASE = 275;
	localparam int PHASES         = 6;

	typedef enum {ROW_BYTE, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t    op;
		logic [7:0] val;
		reg_idx_t   idx;
		bit         typed;
		res_t       want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [2:0] column_number;
	logic [7:0] field_length;
	logic       line_done;
	logic [2:0] column_count;
	logic [1:0] error_code;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'h00;

	// split state and registers as the block should hold them
	logic [7:0] c_delim = RST_DELIMITER;
	logic [7:0] c_quote = RST_QUOTE;
	logic [2:0] c_maxcol = RST_MAX_COLUMNS;
	bit         p_in_quotes;
	bit         p_quote_wait;
	int         p_col;
	int         p_len;
	bit         p_skip;

	res_t       pending_tokens[$];
	dir_row_t   dir_rows[$];
	int         mismatches;
	int         bytes_sent;
	int         cycles;
	int         stall_hold;
	bit         steady;

	delimited_quoted_field_splitter u_dut (.*);

	always #10 clk = ~clk;

	function automatic res_t mk_res(kind_t k, logic [7:0] d, int col, int len, bit done,
			int cnt, err_t e);
		res_t r;
		r.kind = k;
		r.data_byte = d;
		r.column_number = 3'(col);
		r.field_length = 8'(len);
		r.line_done = done;
		r.column_count = 3'(cnt);
		r.error_code = e;
		return r;
	endfunction

	function automatic void add_row(row_op_t op, logic [7:0] v, reg_idx_t idx = REG_DELIMITER,
			bit typed = 1'b0, res_t want = '0);
		dir_row_t r;
		r.op = op;
		r.val = v;
		r.idx = idx;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	function automatic void drop_line();
		p_in_quotes = 1'b0;
		p_quote_wait = 1'b0;
		p_col = 0;
		p_len = 0;
	endfunction

	function automatic bit keep_byte(logic [7:0] b, inout res_t r);
		if (p_len + 1 >= DEF_FIELD_CAPACITY) begin
			r.kind = KIND_ERROR;
			r.error_code = ERR_LONG;
			drop_line();
			p_skip = 1'b1;
		end else begin
			p_len++;
			r.kind = KIND_DATA;
			r.data_byte = b;
		end
		return 1'b1;
	endfunction

	function automatic bit split_byte(logic [7:0] b, output res_t r);
		bit eol;
		int lim;
		eol = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
		lim = (c_maxcol == 0 || c_maxcol > DEF_COLUMN_LIMIT) ? DEF_COLUMN_LIMIT : c_maxcol;
		r = '0;
		r.column_number = 3'(p_col);
		if (p_skip) begin
			if (eol) begin
				p_skip = 1'b0;
				drop_line();
			end
			return 1'b0;
		end
		if (p_quote_wait) begin
			p_quote_wait = 1'b0;
			if (b == c_quote)
				return keep_byte(b, r);
			p_in_quotes = 1'b0;
		end else if (b == c_quote) begin
			if (p_in_quotes)
				p_quote_wait = 1'b1;
			else
				p_in_quotes = 1'b1;
			return 1'b0;
		end
		if (p_in_quotes) begin
			if (eol) begin
				r.kind = KIND_ERROR;
				r.line_done = 1'b1;
				r.error_code = ERR_QUOTE;
				drop_line();
				return 1'b1;
			end
			return keep_byte(b, r);
		end
		if (eol || b == c_delim) begin
			if (p_col >= lim) begin
				r.kind = KIND_ERROR;
				r.error_code = ERR_COLUMNS;
				r.line_done = eol;
				drop_line();
				p_skip = !eol;
				return 1'b1;
			end
			r.kind = KIND_END;
			r.field_length = 8'(p_len);
			if (eol) begin
				r.line_done = 1'b1;
				r.column_count = 3'(p_col + 1);
				drop_line();
			end else begin
				p_col++;
				p_len = 0;
			end
			return 1'b1;
		end
		return keep_byte(b, r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		if ($urandom_range(0, 11) == 0)
			return 8'($urandom_range(0, 255));
		c = 8'($urandom_range(32, 126));
		for (int i = 0; i < 4 && (c == c_delim || c == c_quote); i++)
			c = 8'($urandom_range(32, 126));
		return c;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
	endtask

	task automatic chk_field(string name, int got, int want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	task automatic send_byte(logic [7:0] b, bit typed = 1'b0, res_t want = '0);
		int gap;
		res_t got;
		bit has;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		has = split_byte(b, got);
		if (typed)
			pending_tokens.push_back(want);
		else if (has)
			pending_tokens.push_back(got);
		bytes_sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] v);
		in_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DELIMITER: c_delim = v;
			REG_QUOTE: c_quote = v;
			REG_MAX_COLUMNS: c_maxcol = v[2:0];
			default: ;
		endcase
	endtask

	task automatic send_field();
		int len;
		bit quoted;
		len = ($urandom_range(0, 149) == 0) ? $urandom_range(253, 258) : $urandom_range(0, 8);
		quoted = ($urandom_range(0, 2) == 0);
		if (quoted)
			send_byte(c_quote);
		for (int i = 0; i < len; i++) begin
			if (quoted && $urandom_range(0, 7) == 0) begin
				send_byte(c_quote);
				send_byte(c_quote);
			end else begin
				send_byte(text_char());
			end
		end
		if (quoted && $urandom_range(0, 19) != 0)
			send_byte(c_quote);
	endtask

	task automatic send_line();
		int nf;
		int r;
		steady = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 9) == 0) begin
			nf = $urandom_range(0, 12);
			for (int i = 0; i < nf; i++)
				send_byte(8'($urandom_range(0, 255)));
		end else begin
			nf = $urandom_range(1, 8);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					send_byte(c_delim);
				send_field();
			end
		end
		r = $urandom_range(0, 2);
		send_byte(r == 0 ? CH_NUL : (r == 1 ? CH_LF : CH_CR));
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin : stall_gen
		int r;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_ready <= 1'b1;
				stall_hold <= $urandom_range(1, 40);
			end else if (r < 90) begin
				out_ready <= 1'($urandom_range(0, 1));
				stall_hold <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				stall_hold <= $urandom_range(5, 30);
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("result with no item waiting, kind", kind, -1);
			end else begin
				want = pending_tokens.pop_front();
				chk_field("kind", kind, want.kind);
				chk_field("data_byte", data_byte, want.data_byte);
				chk_field("column_number", column_number, want.column_number);
				chk_field("field_length", field_length, want.field_length);
				chk_field("line_done", line_done, want.line_done);
				chk_field("column_count", column_count, want.column_count);
				chk_field("error_code", error_code, want.error_code);
			end
		end
	end

	initial begin
		int phase_start;
		logic [7:0] d;
		drop_line();
		p_skip = 1'b0;

		add_row(ROW_BYTE, "a", REG_DELIMITER, 1'b1,
			mk_res(KIND_DATA, "a", 0, 0, 1'b0, 0, ERR_LONG));
		add_row(ROW_BYTE, RST_DELIMITER, REG_DELIMITER, 1'b1,
			mk_res(KIND_END, 8'h00, 0, 1, 1'b0, 0, ERR_LONG));
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, "x");
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, RST_DELIMITER);
		add_row(ROW_BYTE, 8'hff, REG_DELIMITER, 1'b1,
			mk_res(KIND_DATA, 8'hff, 2, 0, 1'b0, 0, ERR_LONG));
		add_row(ROW_BYTE, CH_NUL, REG_DELIMITER, 1'b1,
			mk_res(KIND_END, 8'h00, 2, 1, 1'b1, 3, ERR_LONG));
		add_row(ROW_BYTE, CH_LF, REG_DELIMITER, 1'b1,
			mk_res(KIND_END, 8'h00, 0, 0, 1'b1, 1, ERR_LONG));
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, "b");
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, CH_CR);
		add_row(ROW_BYTE, RST_QUOTE);
		add_row(ROW_BYTE, CH_CR, REG_DELIMITER, 1'b1,
			mk_res(KIND_ERROR, 8'h00, 0, 0, 1'b1, 0, ERR_QUOTE));
		add_row(ROW_CFG, 8'd1, REG_MAX_COLUMNS);
		add_row(ROW_BYTE, RST_DELIMITER);
		add_row(ROW_BYTE, RST_DELIMITER, REG_DELIMITER, 1'b1,
			mk_res(KIND_ERROR, 8'h00, 1, 0, 1'b0, 0, ERR_COLUMNS));
		add_row(ROW_BYTE, "z");
		add_row(ROW_BYTE, CH_LF);
		add_row(ROW_BYTE, RST_DELIMITER);
		add_row(ROW_BYTE, CH_LF, REG_DELIMITER, 1'b1,
			mk_res(KIND_ERROR, 8'h00, 1, 0, 1'b1, 0, ERR_COLUMNS));
		add_row(ROW_CFG, 8'd0, REG_MAX_COLUMNS);
		add_row(ROW_CFG, CH_CR, REG_DELIMITER);
		add_row(ROW_BYTE, CH_CR, REG_DELIMITER, 1'b1,
			mk_res(KIND_END, 8'h00, 0, 0, 1'b1, 1, ERR_LONG));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_CFG)
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			else
				send_byte(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_DELIMITER, RST_DELIMITER);
					write_reg(REG_QUOTE, RST_QUOTE);
					write_reg(REG_MAX_COLUMNS, 8'(RST_MAX_COLUMNS));
				end
				1: begin
					write_reg(REG_DELIMITER, 8'h00);
					write_reg(REG_QUOTE, 8'hff);
					write_reg(REG_MAX_COLUMNS, 8'd7);
				end
				2: begin
					write_reg(REG_DELIMITER, 8'hff);
					write_reg(REG_QUOTE, 8'h00);
					write_reg(REG_MAX_COLUMNS, 8'd1);
				end
				3: begin
					write_reg(REG_DELIMITER, ",");
					write_reg(REG_QUOTE, "'");
					write_reg(REG_MAX_COLUMNS, 8'($urandom_range(0, 255)));
				end
				4: begin
					write_reg(REG_DELIMITER, 8'($urandom_range(0, 255)));
					write_reg(REG_QUOTE, 8'($urandom_range(0, 255)));
					write_reg(REG_MAX_COLUMNS, 8'($urandom_range(0, 255)));
				end
				default: begin
					d = 8'($urandom_range(0, 255));
					write_reg(REG_DELIMITER, d);
					write_reg(REG_QUOTE, d);
					write_reg(REG_MAX_COLUMNS, 8'($urandom_range(0, 255)));
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent < phase_start + ITEMS_PER_PHASE)
				send_line();
		end

		in_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
